FILE: hdl/rat_acc_pkg.sv
// Shared types, codes and constants for the rational accumulator.
package rat_acc_pkg;

	localparam int DefValueBits = 32;
	localparam int MagBits = 64;

	typedef enum logic [2:0] {
		OP_LOAD = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// Command into the shared 64-bit arithmetic unit.
	typedef enum logic [3:0] {
		ALU_MUL = 4'b0001,
		ALU_GCD = 4'b0010,
		ALU_DIV = 4'b0100,
		ALU_NOP = 4'b1000
	} alu_cmd_t;

	typedef struct packed {
		logic     start;
		alu_cmd_t cmd;
	} alu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_sts_t;

endpackage

FILE: hdl/rat_acc_alu.sv
// Shared multicycle unit: 32x32 multiply, binary-shift gcd by subtraction, 64-bit divide.
module rat_acc_alu (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rat_acc_pkg::alu_ctl_t  ctl,
	input  logic [63:0]            a,
	input  logic [63:0]            b,
	output rat_acc_pkg::alu_sts_t  sts,
	output logic [63:0]            y
);

	typedef enum logic [3:0] {
		U_IDLE = 4'b0001,
		U_MUL  = 4'b0010,
		U_GCD  = 4'b0100,
		U_DIV  = 4'b1000
	} ustate_t;

	ustate_t     state_q;
	logic [63:0] x_q, z_q, r_q;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [64:0] rem_sh;
	logic [64:0] rem_sub;

	// Multiply is shift-add, one bit a cycle; divide restoring, one bit a cycle.
	assign rem_sh  = {r_q, x_q[63]};
	assign rem_sub = rem_sh - {1'b0, z_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				U_IDLE: begin
					if (ctl.start) begin
						x_q   <= a;
						z_q   <= b;
						r_q   <= '0;
						cnt_q <= '0;
						case (ctl.cmd)
							rat_acc_pkg::ALU_MUL: state_q <= U_MUL;
							rat_acc_pkg::ALU_GCD: state_q <= U_GCD;
							rat_acc_pkg::ALU_DIV: state_q <= U_DIV;
							default: done_q <= 1'b1;
						endcase
					end
				end
				U_MUL: begin
					if (x_q[cnt_q[4:0]])
						r_q <= r_q + (z_q << cnt_q[4:0]);
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd31) begin
						state_q <= U_IDLE;
						done_q  <= 1'b1;
					end
				end
				U_GCD: begin
					// Euclid by remainder is slow in hardware; use Stein's algorithm.
					// x_q,z_q operands; cnt_q counts common factors of two.
					if (z_q == '0) begin
						r_q     <= x_q << cnt_q[5:0];
						state_q <= U_IDLE;
						done_q  <= 1'b1;
					end else if (x_q == '0) begin
						r_q     <= z_q << cnt_q[5:0];
						state_q <= U_IDLE;
						done_q  <= 1'b1;
					end else if (!x_q[0] && !z_q[0]) begin
						x_q   <= x_q >> 1;
						z_q   <= z_q >> 1;
						cnt_q <= cnt_q + 7'd1;
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!z_q[0]) begin
						z_q <= z_q >> 1;
					end else if (x_q >= z_q) begin
						x_q <= (x_q - z_q) >> 1;
					end else begin
						z_q <= (z_q - x_q) >> 1;
					end
				end
				U_DIV: begin
					if (cnt_q == 7'd63) begin
						// Last quotient bit: the quotient goes to the result register.
						r_q     <= {x_q[62:0], !rem_sub[64]};
						state_q <= U_IDLE;
						done_q  <= 1'b1;
					end else if (!rem_sub[64]) begin
						r_q <= rem_sub[63:0];
						x_q <= {x_q[62:0], 1'b1};
					end else begin
						r_q <= rem_sh[63:0];
						x_q <= {x_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	assign sts.busy = (state_q != U_IDLE);
	assign sts.done = done_q;
	assign y = r_q;

endmodule

FILE: hdl/rational_accumulator_alu.sv
// Top level of the rational accumulator: sequencer, held fraction and output register.
//
// Usage: one input transfer on s_axis carries opcode and the right-hand fraction.
// The block applies it to the held fraction, reduces the result by its gcd and
// presents one result transfer on m_axis: the held fraction after the item and
// a status (ok, zero denominator, overflow). A flagged item leaves the state as
// it was and reports the old fraction.
// Flow: s_axis_tready is high only in idle, so one item is in flight at a
// time. An item goes through up to three multiplies, one gcd and two divides,
// all on the one shared unit in rat_acc_alu. Zero input denominators and
// unused opcodes skip the unit and go straight to the output register.
// The result sits in an output register; a stalled receiver holds the block
// in its wait state until m_axis_tready, then it returns to idle.
// Reset (arst_n low) clears the held fraction to 0/1 and drops m_axis_tvalid.
module rational_accumulator_alu #(
	parameter int VALUE_BITS = rat_acc_pkg::DefValueBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: [2:0] opcode, [34:3] operand_numerator, [66:35] operand_denominator
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: [31:0] result_numerator, [62:32] result_denominator, [64:63] status
	output logic [71:0] m_axis_tdata
);

	localparam int EffBits = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam logic [63:0] HalfRange = 64'd1 << (EffBits - 1);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_M0    = 11'b00000000010, // an*rd (or an*rn for mul)
		S_M1    = 11'b00000000100, // rn*ad (or ad*rn for div)
		S_M2    = 11'b00000001000, // ad*rd
		S_COMB  = 11'b00000010000,
		S_GCD   = 11'b00000100000,
		S_DN    = 11'b00001000000,
		S_DD    = 11'b00010000000,
		S_CHECK = 11'b00100000000,
		S_OUT   = 11'b01000000000,
		S_WAIT  = 11'b10000000000
	} state_t;

	state_t                 state_q;
	logic                   started_q;
	logic [2:0]             op_q;
	logic                   rn_neg_q, rd_neg_q;
	logic [31:0]            rn_mag_q, rd_mag_q;
	logic signed [31:0]     acc_num_q;
	logic [30:0]            acc_den_q;
	logic [63:0]            p0_q, p1_q, p2_q;
	logic                   p0_neg_q, p1_neg_q;
	logic                   num_neg_q;
	logic [63:0]            num_mag_q, den_mag_q, g_q;
	logic [1:0]             status_q;
	logic                   out_valid_q;
	logic [64:0]            out_data_q;

	rat_acc_pkg::alu_ctl_t  alu_ctl;
	rat_acc_pkg::alu_sts_t  alu_sts;
	logic [63:0]            alu_a, alu_b, alu_y;

	logic                   an_neg;
	logic [31:0]            an_mag;
	logic [31:0]            in_n, in_d;
	logic                   t1_neg;
	logic [63:0]            sum_mag;
	logic                   sum_neg;

	assign in_n   = s_axis_tdata[34:3];
	assign in_d   = s_axis_tdata[66:35];
	assign an_neg = acc_num_q[31];
	assign an_mag = an_neg ? (32'd0 - acc_num_q) : acc_num_q;

	rat_acc_alu u_alu (
		.clk(clk), .arst_n(arst_n), .ctl(alu_ctl), .a(alu_a), .b(alu_b),
		.sts(alu_sts), .y(alu_y)
	);

	// Operand selection for the shared unit.
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_ctl.cmd = rat_acc_pkg::ALU_MUL;
		case (state_q)
			S_M0: begin
				alu_a = {32'd0, an_mag};
				alu_b = {32'd0, (op_q == rat_acc_pkg::OP_MUL) ? rn_mag_q : rd_mag_q};
			end
			S_M1: begin
				alu_a = {32'd0, rn_mag_q};
				alu_b = {33'd0, acc_den_q};
			end
			S_M2: begin
				alu_a = {33'd0, acc_den_q};
				alu_b = {32'd0, rd_mag_q};
			end
			S_GCD: begin
				alu_ctl.cmd = rat_acc_pkg::ALU_GCD;
				alu_a = num_mag_q;
				alu_b = den_mag_q;
			end
			S_DN: begin
				alu_ctl.cmd = rat_acc_pkg::ALU_DIV;
				alu_a = num_mag_q;
				alu_b = g_q;
			end
			S_DD: begin
				alu_ctl.cmd = rat_acc_pkg::ALU_DIV;
				alu_a = den_mag_q;
				alu_b = g_q;
			end
			default: ;
		endcase
		alu_ctl.start = !started_q && !alu_sts.busy &&
			(state_q == S_M0 || state_q == S_M1 || state_q == S_M2 ||
			 state_q == S_GCD || state_q == S_DN || state_q == S_DD);
	end

	// Signed add of the two cross products; t1 negated for subtract.
	always_comb begin
		t1_neg = p1_neg_q ^ (op_q == rat_acc_pkg::OP_SUB);
		if (p1_q == '0)
			t1_neg = 1'b0;
		if (p0_neg_q == t1_neg) begin
			sum_neg = p0_neg_q;
			sum_mag = p0_q + p1_q;
		end else if (p0_q >= p1_q) begin
			sum_neg = p0_neg_q;
			sum_mag = p0_q - p1_q;
		end else begin
			sum_neg = t1_neg;
			sum_mag = p1_q - p0_q;
		end
		if (sum_mag == '0)
			sum_neg = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			started_q   <= 1'b0;
			acc_num_q   <= '0;
			acc_den_q   <= 31'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (alu_ctl.start)
				started_q <= 1'b1;
			if (alu_sts.done)
				started_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q     <= s_axis_tdata[2:0];
						rn_neg_q <= in_n[31];
						rn_mag_q <= in_n[31] ? (32'd0 - in_n) : in_n;
						rd_neg_q <= in_d[31];
						rd_mag_q <= in_d[31] ? (32'd0 - in_d) : in_d;
						status_q <= rat_acc_pkg::ST_OK;
						if (in_d == '0) begin
							status_q <= rat_acc_pkg::ST_ZERO_DEN;
							state_q  <= S_OUT;
						end else if (s_axis_tdata[2:0] == rat_acc_pkg::OP_LOAD) begin
							state_q <= S_COMB;
						end else if (s_axis_tdata[2:0] > rat_acc_pkg::OP_DIV) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_M0;
						end
					end
				end
				S_M0: if (alu_sts.done) begin
					p0_q     <= alu_y;
					p0_neg_q <= an_neg ^ ((op_q == rat_acc_pkg::OP_MUL) ? rn_neg_q : rd_neg_q);
					state_q  <= (op_q == rat_acc_pkg::OP_MUL) ? S_M2 : S_M1;
				end
				S_M1: if (alu_sts.done) begin
					p1_q     <= alu_y;
					p1_neg_q <= rn_neg_q;
					state_q  <= (op_q == rat_acc_pkg::OP_DIV) ? S_COMB : S_M2;
				end
				S_M2: if (alu_sts.done) begin
					p2_q    <= alu_y;
					state_q <= S_COMB;
				end
				S_COMB: begin
					// Form num/den with sign carried on the numerator.
					case (op_q)
						rat_acc_pkg::OP_LOAD: begin
							num_mag_q <= {32'd0, rn_mag_q};
							num_neg_q <= rn_neg_q ^ rd_neg_q;
							den_mag_q <= {32'd0, rd_mag_q};
						end
						rat_acc_pkg::OP_ADD, rat_acc_pkg::OP_SUB: begin
							num_mag_q <= sum_mag;
							num_neg_q <= sum_neg ^ rd_neg_q;
							den_mag_q <= p2_q;
						end
						rat_acc_pkg::OP_MUL: begin
							num_mag_q <= p0_q;
							num_neg_q <= p0_neg_q ^ rd_neg_q;
							den_mag_q <= p2_q;
						end
						default: begin
							num_mag_q <= p0_q;
							num_neg_q <= p0_neg_q ^ rn_neg_q;
							den_mag_q <= p1_q;
						end
					endcase
					if (op_q == rat_acc_pkg::OP_DIV && p1_q == '0) begin
						status_q <= rat_acc_pkg::ST_ZERO_DEN;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_GCD;
					end
				end
				S_GCD: if (alu_sts.done) begin
					g_q     <= alu_y;
					state_q <= S_DN;
				end
				S_DN: if (alu_sts.done) begin
					num_mag_q <= alu_y;
					state_q   <= S_DD;
				end
				S_DD: if (alu_sts.done) begin
					den_mag_q <= alu_y;
					state_q   <= S_CHECK;
				end
				S_CHECK: begin
					if (den_mag_q > HalfRange - 64'd1 ||
						num_mag_q > ((num_neg_q && num_mag_q != '0) ? HalfRange :
						HalfRange - 64'd1)) begin
						status_q <= rat_acc_pkg::ST_OVERFLOW;
					end else begin
						acc_num_q <= num_neg_q ? (32'd0 - num_mag_q[31:0]) : num_mag_q[31:0];
						acc_den_q <= den_mag_q[30:0];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					out_data_q  <= {status_q, acc_den_q, acc_num_q};
					out_valid_q <= 1'b1;
					state_q     <= S_WAIT;
				end
				S_WAIT: begin
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_data_q};

	// Held denominator is never zero.
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		acc_den_q != '0) else $error("held denominator zero");
	// No input is taken while a result is pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept during output");
	// The shared unit is only started when idle.
	a_alu_start: assert property (@(posedge clk) disable iff (!arst_n)
		alu_ctl.start |-> !alu_sts.busy) else $error("unit restarted while busy");
	// Flagged items leave the held numerator unchanged.
	a_keep_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && status_q != rat_acc_pkg::ST_OK) |=> $stable(acc_num_q))
		else $error("state changed on error");

endmodule
